>>> rtl/rbs_pkg.sv
`default_nettype none

package rbs_pkg;

   localparam int DivBits = 32;
   localparam int DivLat = DivBits + 2;
   localparam int NumRegs = 6;

   localparam logic [2:0] RegBoxMinX = 3'd0;
   localparam logic [2:0] RegBoxMinY = 3'd1;
   localparam logic [2:0] RegBoxMinZ = 3'd2;
   localparam logic [2:0] RegBoxMaxX = 3'd3;
   localparam logic [2:0] RegBoxMaxY = 3'd4;
   localparam logic [2:0] RegBoxMaxZ = 3'd5;

   localparam logic OpRay = 1'b0;
   localparam logic OpInside = 1'b1;

   localparam logic signed [31:0] QMax = 32'sh7fffffff;
   localparam logic signed [31:0] QMin = 32'sh80000000;

   typedef struct packed {
      logic        opcode;
      logic        in_box;
      logic        zmiss;
      logic [2:0]  dirz;
      logic [2:0][31:0] org;
      logic [2:0][31:0] dir;
      logic [31:0] tn;
      logic [31:0] tf;
   } side_type;

   function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
      logic signed [31:0] r;
      if (v > 49'sd2147483647) begin
         r = QMax;
      end else if (v < -49'sd2147483648) begin
         r = QMin;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/rbs_req_if.sv
`default_nettype none

interface rbs_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   logic signed [31:0] t_near;
   logic signed [31:0] t_far;
   modport source(output valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_near, t_far, input ready);
   modport sink(input valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                t_near, t_far, output ready);
endinterface

`default_nettype wire

>>> rtl/rbs_rsp_if.sv
`default_nettype none

interface rbs_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic inside_res;
   logic signed [31:0] hit_t;
   logic signed [31:0] hit_x;
   logic signed [31:0] hit_y;
   logic signed [31:0] hit_z;
   modport source(output valid, hit, inside_res, hit_t, hit_x, hit_y, hit_z, input ready);
   modport sink(input valid, hit, inside_res, hit_t, hit_x, hit_y, hit_z, output ready);
endinterface

`default_nettype wire

>>> rtl/rbs_div.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
module rbs_div (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [47:0]       num_mag,
   input  wire logic [31:0]       den_mag,
   input  wire logic              neg,
   output logic signed [31:0]     quo
);

   logic [47:0] r_ff [rbs_pkg::DivBits+1];
   logic [31:0] q_ff [rbs_pkg::DivBits+1];
   logic [31:0] den_ff [rbs_pkg::DivBits+1];
   logic        neg_ff [rbs_pkg::DivBits+1];
   logic        ovf_ff [rbs_pkg::DivBits+1];
   logic signed [31:0] quo_ff;
   logic signed [31:0] quo_in;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= num_mag;
         q_ff[0] <= '0;
         den_ff[0] <= den_mag;
         neg_ff[0] <= neg;
         ovf_ff[0] <= {16'd0, num_mag} >= {den_mag, 32'd0};
      end
   end

   for (genvar k = 0; k < rbs_pkg::DivBits; k++) begin : g_stage
      logic [63:0] trial;
      logic [31:0] q_in;
      always_comb begin
         trial = {16'd0, r_ff[k]} - ({32'd0, den_ff[k]} << (rbs_pkg::DivBits - 1 - k));
         q_in = q_ff[k];
         q_in[rbs_pkg::DivBits - 1 - k] = !trial[63];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1] <= trial[63] ? r_ff[k] : trial[47:0];
            q_ff[k+1] <= q_in;
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_comb begin
      if (!neg_ff[rbs_pkg::DivBits]) begin
         if (ovf_ff[rbs_pkg::DivBits] || q_ff[rbs_pkg::DivBits][31]) begin
            quo_in = rbs_pkg::QMax;
         end else begin
            quo_in = q_ff[rbs_pkg::DivBits];
         end
      end else begin
         if (ovf_ff[rbs_pkg::DivBits] || q_ff[rbs_pkg::DivBits] > 32'h80000000) begin
            quo_in = rbs_pkg::QMin;
         end else begin
            quo_in = -q_ff[rbs_pkg::DivBits];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

>>> rtl/ray_box_slab_intersect.sv
`default_nettype none

// Ray versus axis-aligned box test in signed Q16.16. Program the six corner
// registers, then send items: opcode 0 runs the slab ray test and returns hit,
// distance and hit point, opcode 1 returns whether the origin lies strictly inside
// the box. One item enters per cycle unless a stalled result holds the pipeline;
// the six pipelined dividers produce one quotient bit per stage. A stalled result
// holds the whole pipeline. Write the registers only when no item is in flight.
module ray_box_slab_intersect (
   input  wire logic  clock,
   input  wire logic  reset,
   rbs_req_if.sink    req_chan,
   rbs_rsp_if.source  rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic signed [31:0] box_min_ff [3];
   logic signed [31:0] box_max_ff [3];
   logic [2:0] reg_idx;
   logic adv;

   assign reg_idx = paddr[4:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            rbs_pkg::RegBoxMinX: box_min_ff[0] <= pwdata;
            rbs_pkg::RegBoxMinY: box_min_ff[1] <= pwdata;
            rbs_pkg::RegBoxMinZ: box_min_ff[2] <= pwdata;
            rbs_pkg::RegBoxMaxX: box_max_ff[0] <= pwdata;
            rbs_pkg::RegBoxMaxY: box_max_ff[1] <= pwdata;
            rbs_pkg::RegBoxMaxZ: box_max_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rbs_pkg::RegBoxMinX: prdata = box_min_ff[0];
         rbs_pkg::RegBoxMinY: prdata = box_min_ff[1];
         rbs_pkg::RegBoxMinZ: prdata = box_min_ff[2];
         rbs_pkg::RegBoxMaxX: prdata = box_max_ff[0];
         rbs_pkg::RegBoxMaxY: prdata = box_max_ff[1];
         rbs_pkg::RegBoxMaxZ: prdata = box_max_ff[2];
         default: prdata = '0;
      endcase
   end

   // Input stage.
   logic v0_ff;
   logic op0_ff;
   logic signed [31:0] org0_ff [3];
   logic signed [31:0] dir0_ff [3];
   logic signed [31:0] tn0_ff, tf0_ff;

   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op0_ff <= req_chan.opcode;
         org0_ff[0] <= req_chan.origin_x;
         org0_ff[1] <= req_chan.origin_y;
         org0_ff[2] <= req_chan.origin_z;
         dir0_ff[0] <= req_chan.dir_x;
         dir0_ff[1] <= req_chan.dir_y;
         dir0_ff[2] <= req_chan.dir_z;
         tn0_ff <= req_chan.t_near;
         tf0_ff <= req_chan.t_far;
      end
   end

   // Slab distances and per-axis checks.
   logic signed [31:0] qmin [3];
   logic signed [31:0] qmax [3];
   rbs_pkg::side_type side0;
   logic [2:0] ins_ax, zm_ax;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      logic signed [32:0] dlo, dhi, dneg;
      logic [31:0] mlo, mhi, mdir;
      always_comb begin
         dlo = {box_min_ff[a][31], box_min_ff[a]} - {org0_ff[a][31], org0_ff[a]};
         dhi = {box_max_ff[a][31], box_max_ff[a]} - {org0_ff[a][31], org0_ff[a]};
         dneg = -{dir0_ff[a][31], dir0_ff[a]};
         mlo = dlo[32] ? 32'(-dlo) : dlo[31:0];
         mhi = dhi[32] ? 32'(-dhi) : dhi[31:0];
         mdir = dir0_ff[a][31] ? dneg[31:0] : dir0_ff[a];
         ins_ax[a] = (org0_ff[a] > box_min_ff[a]) && (org0_ff[a] < box_max_ff[a]);
         zm_ax[a] = (dir0_ff[a] == '0)
                    && ((org0_ff[a] < box_min_ff[a]) || (org0_ff[a] > box_max_ff[a]));
      end
      rbs_div u_div_lo (
         .clock   (clock),
         .en      (adv),
         .num_mag ({mlo, 16'd0}),
         .den_mag (mdir),
         .neg     (dlo[32] ^ dir0_ff[a][31]),
         .quo     (qmin[a])
      );
      rbs_div u_div_hi (
         .clock   (clock),
         .en      (adv),
         .num_mag ({mhi, 16'd0}),
         .den_mag (mdir),
         .neg     (dhi[32] ^ dir0_ff[a][31]),
         .quo     (qmax[a])
      );
   end

   always_comb begin
      side0.opcode = op0_ff;
      side0.in_box = &ins_ax;
      side0.zmiss = |zm_ax;
      for (int i = 0; i < 3; i++) begin
         side0.dirz[i] = (dir0_ff[i] == '0);
         side0.org[i] = org0_ff[i];
         side0.dir[i] = dir0_ff[i];
      end
      side0.tn = tn0_ff;
      side0.tf = tf0_ff;
   end

   rbs_pkg::side_type side_ff [rbs_pkg::DivLat];
   logic [rbs_pkg::DivLat-1:0] vd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= '0;
      end else if (adv) begin
         vd_ff <= {vd_ff[rbs_pkg::DivLat-2:0], v0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side0;
         for (int i = 1; i < rbs_pkg::DivLat; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   rbs_pkg::side_type sd;
   assign sd = side_ff[rbs_pkg::DivLat-1];

   // Stage A: ordered entry and exit per axis.
   logic va_ff;
   rbs_pkg::side_type sa_ff;
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] hi_ff [3];
   logic signed [31:0] lo_in [3];
   logic signed [31:0] hi_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (sd.dirz[i]) begin
            lo_in[i] = rbs_pkg::QMin;
            hi_in[i] = rbs_pkg::QMax;
         end else if (qmin[i] < qmax[i]) begin
            lo_in[i] = qmin[i];
            hi_in[i] = qmax[i];
         end else begin
            lo_in[i] = qmax[i];
            hi_in[i] = qmin[i];
         end
      end
   end

   // Stage B: largest entry, smallest exit.
   logic vb_ff;
   rbs_pkg::side_type sb_ff;
   logic signed [31:0] enter_ff, leave_ff, enter_in, leave_in;

   always_comb begin
      enter_in = lo_ff[0];
      leave_in = hi_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (lo_ff[i] > enter_in) begin
            enter_in = lo_ff[i];
         end
         if (hi_ff[i] < leave_in) begin
            leave_in = hi_ff[i];
         end
      end
   end

   // Stage C: distance choice.
   logic vc_ff;
   rbs_pkg::side_type sc_ff;
   logic hit_c_ff, hit_c_in;
   logic signed [31:0] t_c_ff, t_c_in;
   logic enter_ok;

   always_comb begin
      enter_ok = (enter_ff >= 0) && (enter_ff >= $signed(sb_ff.tn))
                 && (enter_ff <= $signed(sb_ff.tf));
      t_c_in = enter_ok ? enter_ff : leave_ff;
      hit_c_in = (sb_ff.opcode == rbs_pkg::OpRay) && !sb_ff.zmiss && (enter_ff <= leave_ff)
                 && (t_c_in >= $signed(sb_ff.tn)) && (t_c_in <= $signed(sb_ff.tf));
   end

   // Stage D: products.
   logic vd2_ff;
   rbs_pkg::side_type sdd_ff;
   logic hit_d_ff;
   logic signed [31:0] t_d_ff;
   logic signed [63:0] prod_ff [3];

   // Output register.
   logic hit_ff, inside_ff;
   logic signed [31:0] t_out_ff;
   logic signed [31:0] pt_ff [3];
   logic signed [31:0] pt_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt_in[i] = rbs_pkg::sat49(49'(prod_ff[i] >>> 16) + 49'($signed(sdd_ff.org[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd2_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= vd_ff[rbs_pkg::DivLat-1];
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd2_ff <= vc_ff;
         out_valid_ff <= vd2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff <= sd;
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
         sb_ff <= sa_ff;
         enter_ff <= enter_in;
         leave_ff <= leave_in;
         sc_ff <= sb_ff;
         hit_c_ff <= hit_c_in;
         t_c_ff <= t_c_in;
         sdd_ff <= sc_ff;
         hit_d_ff <= hit_c_ff;
         t_d_ff <= t_c_ff;
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= t_c_ff * $signed(sc_ff.dir[i]);
         end
         hit_ff <= hit_d_ff;
         inside_ff <= (sdd_ff.opcode == rbs_pkg::OpInside) && sdd_ff.in_box;
         t_out_ff <= hit_d_ff ? t_d_ff : '0;
         for (int i = 0; i < 3; i++) begin
            pt_ff[i] <= hit_d_ff ? pt_in[i] : '0;
         end
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.hit = hit_ff;
   assign rsp_chan.inside_res = inside_ff;
   assign rsp_chan.hit_t = t_out_ff;
   assign rsp_chan.hit_x = pt_ff[0];
   assign rsp_chan.hit_y = pt_ff[1];
   assign rsp_chan.hit_z = pt_ff[2];

   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(hit_ff && inside_ff))
      else $error("hit and inside both set");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !hit_ff |-> t_out_ff == '0 && pt_ff[0] == '0)
      else $error("miss carries nonzero distance or point");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("item taken while pipeline stalled");

   a_hit_interval: assert property (@(posedge clock) disable iff (reset)
      vc_ff && hit_c_ff |-> t_c_ff <= $signed(sc_ff.tf) && t_c_ff >= $signed(sc_ff.tn))
      else $error("hit distance outside interval");

endmodule

`default_nettype wire

>>> bench/tb_ray_box_slab_intersect.sv
`default_nettype none

module tb_ray_box_slab_intersect;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        opcode;
      logic signed [31:0] org[3];
      logic signed [31:0] dir[3];
      logic signed [31:0] tn;
      logic signed [31:0] tf;
   } ray_item_type;

   typedef struct {
      logic        hit;
      logic        in_box;
      logic signed [31:0] t;
      logic signed [31:0] pt[3];
   } ray_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   rbs_req_if req_chan ();
   rbs_rsp_if rsp_chan ();

   ray_box_slab_intersect dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
      .prdata(prdata), .pready(pready)
   );

   logic signed [31:0] box_lo[3];
   logic signed [31:0] box_hi[3];
   ray_result_type expected_results[$];
   int errors = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.opcode = 1'b0;
      req_chan.origin_x = '0;
      req_chan.origin_y = '0;
      req_chan.origin_z = '0;
      req_chan.dir_x = '0;
      req_chan.dir_y = '0;
      req_chan.dir_z = '0;
      req_chan.t_near = '0;
      req_chan.t_far = '0;
      rsp_chan.ready = 1'b0;
   end

   function automatic logic signed [63:0] sat_q(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic ray_result_type predict_hit(input ray_item_type it);
      ray_result_type r;
      logic signed [63:0] enter, leave, a, b, lo, hi, t, prod, fl;
      logic miss;
      r.hit = 1'b0;
      r.in_box = 1'b0;
      r.t = '0;
      r.pt[0] = '0;
      r.pt[1] = '0;
      r.pt[2] = '0;
      enter = -64'sd2147483648;
      leave = 64'sd2147483647;
      miss = 1'b0;
      if (it.opcode == rbs_pkg::OpInside) begin
         r.in_box = 1'b1;
         for (int i = 0; i < 3; i++)
            if (it.org[i] <= box_lo[i] || it.org[i] >= box_hi[i]) r.in_box = 1'b0;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         if (it.dir[i] == 0) begin
            if (it.org[i] < box_lo[i] || it.org[i] > box_hi[i]) miss = 1'b1;
         end else begin
            a = sat_q(((64'(box_lo[i]) - 64'(it.org[i])) * 64'sd65536) / 64'(it.dir[i]));
            b = sat_q(((64'(box_hi[i]) - 64'(it.org[i])) * 64'sd65536) / 64'(it.dir[i]));
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            if (lo > enter) enter = lo;
            if (hi < leave) leave = hi;
         end
      end
      if (miss || enter > leave) return r;
      t = (enter < 0) ? leave : enter;
      if (t > 64'(it.tf) || t < 64'(it.tn)) begin
         if (enter < 0) return r;
         t = leave;
         if (t > 64'(it.tf) || t < 64'(it.tn)) return r;
      end
      for (int i = 0; i < 3; i++) begin
         prod = t * 64'(it.dir[i]);
         fl = prod >>> 16;
         r.pt[i] = 32'(sat_q(64'(it.org[i]) + fl));
      end
      r.hit = 1'b1;
      r.t = 32'(t);
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("ray_box_slab_intersect test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      ray_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.hit !== want.hit) begin
               $error("hit expected %0d actual %0d", want.hit, rsp_chan.hit);
               errors++;
            end
            if (rsp_chan.inside_res !== want.in_box) begin
               $error("inside_res expected %0d actual %0d", want.in_box, rsp_chan.inside_res);
               errors++;
            end
            if (rsp_chan.hit_t !== want.t) begin
               $error("hit_t expected %0d actual %0d", want.t, rsp_chan.hit_t);
               errors++;
            end
            if (rsp_chan.hit_x !== want.pt[0]) begin
               $error("hit_x expected %0d actual %0d", want.pt[0], rsp_chan.hit_x);
               errors++;
            end
            if (rsp_chan.hit_y !== want.pt[1]) begin
               $error("hit_y expected %0d actual %0d", want.pt[1], rsp_chan.hit_y);
               errors++;
            end
            if (rsp_chan.hit_z !== want.pt[2]) begin
               $error("hit_z expected %0d actual %0d", want.pt[2], rsp_chan.hit_z);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_ray(input ray_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.opcode = it.opcode;
      req_chan.origin_x = it.org[0];
      req_chan.origin_y = it.org[1];
      req_chan.origin_z = it.org[2];
      req_chan.dir_x = it.dir[0];
      req_chan.dir_y = it.dir[1];
      req_chan.dir_z = it.dir[2];
      req_chan.t_near = it.tn;
      req_chan.t_far = it.tf;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_hit(it));
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic write_box_reg(input logic [2:0] idx, input logic signed [31:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (idx < 3) box_lo[idx] = value;
      else box_hi[idx - 3] = value;
   endtask

   task automatic set_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      write_box_reg(rbs_pkg::RegBoxMinX, lx);
      write_box_reg(rbs_pkg::RegBoxMinY, ly);
      write_box_reg(rbs_pkg::RegBoxMinZ, lz);
      write_box_reg(rbs_pkg::RegBoxMaxX, hx);
      write_box_reg(rbs_pkg::RegBoxMaxY, hy);
      write_box_reg(rbs_pkg::RegBoxMaxZ, hz);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(1) ? rbs_pkg::QMax : rbs_pkg::QMin;
         2: return 0;
         default: return $signed($urandom_range(20 << 16)) - (10 << 16);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_dir();
      case ($urandom_range(7))
         0: return 0;
         1: return $urandom();
         2: return $urandom_range(1) ? rbs_pkg::QMax : rbs_pkg::QMin;
         3: return $urandom_range(1) ? 1 : -1;
         default: return $signed($urandom_range(4 << 16)) - (2 << 16);
      endcase
   endfunction

   function automatic ray_item_type make_ray(input logic op);
      ray_item_type it;
      it.opcode = op;
      for (int i = 0; i < 3; i++) begin
         it.org[i] = rand_coord();
         it.dir[i] = rand_dir();
      end
      case ($urandom_range(3))
         0: begin it.tn = rbs_pkg::QMin; it.tf = rbs_pkg::QMax; end
         1: begin it.tn = $urandom(); it.tf = $urandom(); end
         2: begin it.tn = 0; it.tf = rbs_pkg::QMax; end
         default: begin
            it.tn = $signed($urandom_range(8 << 16)) - (4 << 16);
            it.tf = it.tn + $urandom_range(40 << 16);
         end
      endcase
      return it;
   endfunction

   task automatic test_directed();
      ray_item_type it;
      set_box(-(1 << 16), -(1 << 16), -(1 << 16), 1 << 16, 1 << 16, 1 << 16);
      it.opcode = rbs_pkg::OpRay;
      it.org = '{-(5 << 16), 0, 0};
      it.dir = '{1 << 16, 0, 0};
      it.tn = 0;
      it.tf = rbs_pkg::QMax;
      send_ray(it);
      it.org = '{0, 0, 0};
      send_ray(it);
      it.org = '{0, 2 << 16, 0};
      send_ray(it);
      it.org = '{-(5 << 16), 0, 0};
      it.tn = 10 << 16;
      it.tf = 2 << 16;
      send_ray(it);
      it.tn = 5 << 16;
      it.tf = rbs_pkg::QMax;
      send_ray(it);
      it.org = '{rbs_pkg::QMax, rbs_pkg::QMin, rbs_pkg::QMax};
      it.dir = '{rbs_pkg::QMin, rbs_pkg::QMax, 1};
      it.tn = rbs_pkg::QMin;
      send_ray(it);
      it.org = '{rbs_pkg::QMin, 0, 0};
      it.dir = '{1, 0, 0};
      send_ray(it);
      it.opcode = rbs_pkg::OpInside;
      it.org = '{0, 0, 0};
      send_ray(it);
      it.org = '{1 << 16, 0, 0};
      send_ray(it);
      it.org = '{rbs_pkg::QMax, rbs_pkg::QMin, 0};
      send_ray(it);
      set_box(1 << 16, 0, 0, -(1 << 16), 1 << 16, 1 << 16);
      it.opcode = rbs_pkg::OpRay;
      it.org = '{0, 0, 0};
      it.dir = '{0, 1 << 16, 0};
      it.tn = rbs_pkg::QMin;
      it.tf = rbs_pkg::QMax;
      send_ray(it);
      it.dir = '{1 << 16, 1 << 16, 1 << 16};
      send_ray(it);
      it.opcode = rbs_pkg::OpInside;
      send_ray(it);
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int count);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) send_ray(make_ray($urandom_range(3) == 0));
   endtask

   task automatic test_random();
      set_box(rbs_pkg::QMin, rbs_pkg::QMin, rbs_pkg::QMin,
              rbs_pkg::QMax, rbs_pkg::QMax, rbs_pkg::QMax);
      test_random_phase(0, 0, 100);
      set_box(-(3 << 16), -(2 << 16), -(4 << 16), 3 << 16, 5 << 16, 1 << 16);
      test_random_phase(0, 0, 200);
      test_random_phase(56, 0, 200);
      set_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      test_random_phase(0, 56, 200);
      set_box(-(1 << 16), 0, -(7 << 16), 6 << 16, 2 << 16, 0);
      test_random_phase(26, 26, 200);
      set_box(rbs_pkg::QMax, rbs_pkg::QMax, rbs_pkg::QMax,
              rbs_pkg::QMin, rbs_pkg::QMin, rbs_pkg::QMin);
      test_random_phase(0, 0, 120);
      set_box(0, 0, 0, 0, 0, 0);
      test_random_phase(26, 26, 120);
   endtask

   initial begin
      int drain;
      box_lo = '{0, 0, 0};
      box_hi = '{0, 0, 0};
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      stall_pct = 0;
      drain = 0;
      while (expected_results.size() != 0 && drain < 100000) begin
         @(negedge clock);
         drain++;
      end
      repeat (60) @(negedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("ray_box_slab_intersect test passed");
      end else begin
         $display("ray_box_slab_intersect test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
